### rtl/prqs_pkg.sv
// Shared widths, codes and FSM state type for the priority ready queue scheduler.
`default_nettype none

package prqs_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned PRI_IN_W   = 8;
  localparam int unsigned TIME_IN_W  = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STATUS_W   = 2;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_QUEUE_DEPTH   = 16;
  localparam int unsigned DEF_PRIORITY_BITS = 8;
  localparam int unsigned DEF_TIME_BITS     = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREEMPT = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

### rtl/prqs_if.sv
// Valid/ready channel interfaces for scheduler operations and results.
`default_nettype none

interface prqs_in_if import prqs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ID_W-1:0]      task_id;
  logic [PRI_IN_W-1:0]  task_priority;
  logic [TIME_IN_W-1:0] enqueue_time;

  modport source (output valid, func, task_id, task_priority, enqueue_time, input ready);
  modport sink   (input valid, func, task_id, task_priority, enqueue_time, output ready);
endinterface

interface prqs_out_if import prqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     running_id;
  logic                running_valid;
  logic                switched;
  logic [COUNT_W-1:0]  ready_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, running_id, running_valid, switched, ready_count, status,
                  input ready);
  modport sink   (input valid, running_id, running_valid, switched, ready_count, status,
                  output ready);
endinterface

`default_nettype wire

### rtl/prqs_ready_mem.sv
// Ready queue storage: one write port, one read port with registered read data.
`default_nettype none

module prqs_ready_mem import prqs_pkg::*; #(
  parameter int unsigned DEPTH  = DEF_QUEUE_DEPTH,
  parameter int unsigned DATA_W = ID_W + DEF_PRIORITY_BITS + DEF_TIME_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/priority_ready_queue_scheduler.sv
// Top level of the fixed-priority scheduler with ready queue and one running task.
//
// One operation is taken at a time. Enqueue, full enqueue, suspend or preempt
// with an empty queue and unused codes go straight to the finish state, which
// loads the output register. Otherwise suspend and preempt walk the ready queue
// through the single memory read port, one entry a cycle, through a shared
// priority/time comparator, then, if the chosen task is taken, close the gap
// left by the chosen task one entry a cycle.
// The input is ready again as soon as the result sits in the output register.
`default_nettype none

module priority_ready_queue_scheduler import prqs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS,
  parameter int unsigned TIME_BITS     = DEF_TIME_BITS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  prqs_in_if.sink    in_i,
  prqs_out_if.source out_o
);

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_W + PRIORITY_BITS + TIME_BITS;
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] OneCnt   = CNT_W'(1);

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic [PRIORITY_BITS-1:0] pri;
    logic [TIME_BITS-1:0]     tstamp;
  } entry_t;

  // a ranks strictly ahead of b
  function automatic logic ahead(input entry_t a, input entry_t b);
    logic res;
    if (a.pri != b.pri) begin
      res = a.pri > b.pri;
    end else begin
      res = a.tstamp < b.tstamp;
    end
    return res;
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic              present_q, present_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic              swap_q, swap_d;
  logic              sw_q, sw_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;

  entry_t            running_q, running_d;
  entry_t            best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  entry_t            hold_q, hold_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_rv_q, out_rv_d;
  logic              out_sw_q, out_sw_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  status_e           out_stat_q, out_stat_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t            rd_entry;

  entry_t            cmp_a, cmp_b;
  logic              cmp_ahead;
  logic              in_fire;
  logic [CNT_W-1:0]  ptr_next_cnt;

  prqs_ready_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_entry     = entry_t'(mem_rdata);
  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign ptr_next_cnt = CNT_W'(ptr_q) + OneCnt;

  // Shared comparator: scan candidate vs. best so far, or best vs. running
  always_comb begin
    if (state_q == ST_DECIDE) begin
      cmp_a = best_q;
      cmp_b = running_q;
    end else begin
      cmp_a = rd_entry;
      cmp_b = best_q;
    end
  end
  assign cmp_ahead = ahead(cmp_a, cmp_b);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    present_d   = present_q;
    ptr_d       = ptr_q;
    func_d      = func_q;
    swap_d      = swap_q;
    sw_d        = sw_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    running_d   = running_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    hold_d      = hold_q;
    out_id_d    = out_id_q;
    out_rv_d    = out_rv_q;
    out_sw_d    = out_sw_q;
    out_cnt_d   = out_cnt_q;
    out_stat_d  = out_stat_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = rd_entry;
    mem_raddr   = IDX_W'(ptr_next_cnt);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        mem_raddr = '0;
        if (in_fire) begin
          func_d   = in_i.func;
          swap_d   = 1'b0;
          sw_d     = 1'b0;
          status_d = STAT_OK;
          ptr_d    = '0;
          state_d  = ST_FINISH;
          case (in_i.func)
            FUNC_ENQUEUE: begin
              if (size_q == DepthCnt) begin
                status_d = STAT_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = IDX_W'(size_q);
                mem_wdata.id     = in_i.task_id;
                mem_wdata.pri    = PRIORITY_BITS'(in_i.task_priority);
                mem_wdata.tstamp = TIME_BITS'(in_i.enqueue_time);
                size_d           = size_q + OneCnt;
              end
            end
            FUNC_SUSPEND, FUNC_PREEMPT: begin
              if (size_q == '0) begin
                // preempt with a running task and nothing ready: no change
                if (in_i.func == FUNC_SUSPEND || !present_q) begin
                  sw_d      = present_q;
                  present_d = 1'b0;
                  status_d  = STAT_EMPTY;
                end
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (ptr_q == '0 || cmp_ahead) begin
          best_d     = rd_entry;
          best_idx_d = ptr_q;
        end
        if (ptr_next_cnt == size_q) begin
          state_d = ST_DECIDE;
        end else begin
          ptr_d = IDX_W'(ptr_next_cnt);
        end
      end

      ST_DECIDE: begin
        // prefetch the entry behind the winner for the compaction pass
        mem_raddr = IDX_W'(CNT_W'(best_idx_q) + OneCnt);
        ptr_d     = best_idx_q;
        if (func_q == FUNC_SUSPEND || !present_q) begin
          running_d = best_q;
          present_d = 1'b1;
          sw_d      = 1'b1;
          state_d   = ST_SHIFT;
        end else if (cmp_ahead) begin
          hold_d    = running_q;
          running_d = best_q;
          swap_d    = 1'b1;
          sw_d      = 1'b1;
          state_d   = ST_SHIFT;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_SHIFT: begin
        mem_raddr = IDX_W'(ptr_next_cnt + OneCnt);
        if (ptr_next_cnt < size_q) begin
          mem_we = 1'b1;
          ptr_d  = IDX_W'(ptr_next_cnt);
        end else begin
          // last slot: displaced task goes to the tail, else shrink
          if (swap_q) begin
            mem_we    = 1'b1;
            mem_wdata = hold_q;
          end else begin
            size_d = size_q - OneCnt;
          end
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_id_d    = present_q ? running_q.id : '0;
          out_rv_d    = present_q;
          out_sw_d    = sw_q;
          out_cnt_d   = COUNT_W'(size_q);
          out_stat_d  = status_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      present_q   <= 1'b0;
      ptr_q       <= '0;
      func_q      <= FUNC_ENQUEUE;
      swap_q      <= 1'b0;
      sw_q        <= 1'b0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      present_q   <= present_d;
      ptr_q       <= ptr_d;
      func_q      <= func_d;
      swap_q      <= swap_d;
      sw_q        <= sw_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    running_q  <= running_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    hold_q     <= hold_d;
    out_id_q   <= out_id_d;
    out_rv_q   <= out_rv_d;
    out_sw_q   <= out_sw_d;
    out_cnt_q  <= out_cnt_d;
    out_stat_q <= out_stat_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.running_id    = out_id_q;
  assign out_o.running_valid = out_rv_q;
  assign out_o.switched      = out_sw_q;
  assign out_o.ready_count   = out_cnt_q;
  assign out_o.status        = out_stat_q;

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= DepthCnt)
    else $error("ready queue size beyond depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.func == FUNC_ENQUEUE && size_q != DepthCnt |=>
      size_q == $past(size_q) + OneCnt)
    else $error("enqueue did not grow the ready queue");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.running_valid |-> out_o.running_id == '0)
    else $error("running id reported with no running task");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> size_q != '0 && ptr_next_cnt <= size_q)
    else $error("scan outside the ready queue");
`endif

endmodule

`default_nettype wire

### tb/tb_priority_ready_queue_scheduler.sv
// Self-checking testbench for the priority ready queue scheduler with its own scheduling predictor.
module tb_priority_ready_queue_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import prqs_pkg::*;

  localparam int unsigned QDEPTH      = DEF_QUEUE_DEPTH;
  localparam int          LIMIT       = 1_000_000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 40;
  localparam int          RAND_ITEMS  = 1520;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRI_IN_W-1:0]  pri;
    logic [TIME_IN_W-1:0] stamp;
  } sched_task_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ID_W-1:0]      id;
    logic [PRI_IN_W-1:0]  pri;
    logic [TIME_IN_W-1:0] stamp;
    logic                 drain_first;
  } sched_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    running_id;
    logic               running_valid;
    logic               switched;
    logic [COUNT_W-1:0] ready_count;
    status_e            status;
  } sched_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  prqs_in_if  in_if ();
  prqs_out_if out_if ();

  priority_ready_queue_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  sched_task_t ready_tasks [QDEPTH];
  int          ready_len;
  sched_task_t run_task;
  logic        run_present;

  sched_op_t     pending_ops [$];
  sched_result_t expected_results [$];

  int n_offered, n_accepted, cycles, mismatches;
  int n_enq, n_full, n_empty, n_swaps;
  int tx_gap, rx_stall, hold_left, holds_done;
  bit tx_steady, rx_steady;
  sched_op_t next_op;

  function automatic bit outranks(sched_task_t a, sched_task_t b);
    if (a.pri != b.pri) return a.pri > b.pri;
    return a.stamp < b.stamp;
  endfunction

  // Highest priority, then earliest stamp, then lowest position
  function automatic int best_ready();
    int best;
    best = 0;
    for (int i = 1; i < ready_len; i++)
      if (outranks(ready_tasks[i], ready_tasks[best])) best = i;
    return best;
  endfunction

  function automatic void take_ready(int pos);
    for (int k = pos; k + 1 < ready_len; k++) ready_tasks[k] = ready_tasks[k + 1];
    ready_len--;
  endfunction

  function automatic status_e dispatch_next(output logic sw);
    int b;
    if (ready_len == 0) begin
      sw = run_present;
      run_present = 1'b0;
      run_task = '0;
      n_empty++;
      return STAT_EMPTY;
    end
    b = best_ready();
    run_task = ready_tasks[b];
    run_present = 1'b1;
    take_ready(b);
    sw = 1'b1;
    return STAT_OK;
  endfunction

  function automatic sched_result_t schedule_step(sched_op_t op);
    sched_result_t r;
    sched_task_t   old;
    int            b;
    logic          sw;
    status_e       st;
    sw = 1'b0;
    st = STAT_OK;
    case (op.func)
      FUNC_ENQUEUE: begin
        if (ready_len >= QDEPTH) begin
          st = STAT_FULL;
          n_full++;
        end else begin
          ready_tasks[ready_len] = '{id: op.id, pri: op.pri, stamp: op.stamp};
          ready_len++;
          n_enq++;
        end
      end
      FUNC_SUSPEND: st = dispatch_next(sw);
      FUNC_PREEMPT: begin
        if (!run_present) begin
          st = dispatch_next(sw);
        end else if (ready_len > 0) begin
          b = best_ready();
          if (outranks(ready_tasks[b], run_task)) begin
            // displaced task keeps its stamp and goes to the tail
            old = run_task;
            run_task = ready_tasks[b];
            take_ready(b);
            ready_tasks[ready_len] = old;
            ready_len++;
            sw = 1'b1;
            n_swaps++;
          end
        end
      end
      default: ;
    endcase
    r.running_id    = run_present ? run_task.id : '0;
    r.running_valid = run_present;
    r.switched      = sw;
    r.ready_count   = COUNT_W'(ready_len);
    r.status        = st;
    return r;
  endfunction

  task automatic check_result();
    sched_result_t want, got;
    got.running_id    = out_if.running_id;
    got.running_valid = out_if.running_valid;
    got.switched      = out_if.switched;
    got.ready_count   = out_if.ready_count;
    got.status        = status_e'(out_if.status);
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with nothing outstanding: id %0d valid %0b count %0d",
                 got.running_id, got.running_valid, got.ready_count);
    end else begin
      want = expected_results.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch (exp/act): id %0d/%0d valid %0b/%0b switched %0b/%0b ",
                    "count %0d/%0d status %0d/%0d"},
                   want.running_id, got.running_id, want.running_valid, got.running_valid,
                   want.switched, got.switched, want.ready_count, got.ready_count,
                   want.status, got.status);
      end
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PRI_IN_W-1:0] rand_pri();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 3);
    if (r < 60) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 70) return $urandom_range(252, 255);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [TIME_IN_W-1:0] rand_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 7);
    if (r < 60) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom_range(0, 65535);
  endfunction

  task automatic add_op(logic [FUNC_W-1:0] func, int id, int pri, int stamp, bit drain);
    pending_ops.push_back('{func: func, id: ID_W'(id), pri: PRI_IN_W'(pri),
                            stamp: TIME_IN_W'(stamp), drain_first: drain});
  endtask

  task automatic add_rand(logic [FUNC_W-1:0] func, ref bit drain);
    add_op(func, $urandom_range(0, 15), rand_pri(), rand_stamp(), drain);
    drain = 1'b0;
  endtask

  task automatic build_directed();
    // empty queue, nothing running, unused code
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    add_op(FUNC_UNUSED, 15, 255, 65535, 1'b0);
    // preempt and suspend with a running task and an empty queue
    add_op(FUNC_ENQUEUE, 0, 0, 0, 1'b0);
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    // field extremes, stamp breaks a priority tie
    add_op(FUNC_ENQUEUE, 0, 0, 0, 1'b0);
    add_op(FUNC_ENQUEUE, 15, 255, 65535, 1'b0);
    add_op(FUNC_ENQUEUE, 5, 255, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    // full tie with the running task: no swap
    add_op(FUNC_ENQUEUE, 9, 255, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    // full tie inside the queue: lower position wins
    add_op(FUNC_ENQUEUE, 3, 255, 0, 1'b0);
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    add_op(FUNC_SUSPEND, 0, 0, 0, 1'b0);
    // equal priority, earlier stamp preempts
    add_op(FUNC_ENQUEUE, 12, 255, 10, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    add_op(FUNC_ENQUEUE, 6, 1, 0, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
    // fill to the top, reject one, then swap with a full queue
    for (int k = 0; k < 12; k++) add_op(FUNC_ENQUEUE, k, 16 * k, 65535 - k, 1'b0);
    add_op(FUNC_ENQUEUE, 14, 255, 1, 1'b0);
    add_op(FUNC_ENQUEUE, 13, 200, 5, 1'b0);
    add_op(FUNC_PREEMPT, 0, 0, 0, 1'b0);
  endtask

  task automatic build_random();
    int made, n, w;
    bit drain;
    made = 0;
    drain = 1'b1;
    while (made < RAND_ITEMS) begin
      if ((made >= 700 && made < 720) || (made >= 1300 && made < 1320)) drain = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(6, 18);
          repeat (n) add_rand(FUNC_ENQUEUE, drain);
          w = $urandom_range(1, 4);
          repeat (w) add_rand(FUNC_PREEMPT, drain);
          made += n + w;
        end
        3, 4, 5: begin
          n = $urandom_range(10, 30);
          repeat (n) begin
            w = $urandom_range(0, 99);
            if (w < 45)      add_rand(FUNC_ENQUEUE, drain);
            else if (w < 70) add_rand(FUNC_SUSPEND, drain);
            else if (w < 95) add_rand(FUNC_PREEMPT, drain);
            else             add_rand(FUNC_UNUSED, drain);
          end
          made += n;
        end
        6, 7: begin
          n = $urandom_range(4, 18);
          repeat (n) add_rand($urandom_range(0, 5) == 0 ? FUNC_PREEMPT : FUNC_SUSPEND, drain);
          made += n;
        end
        default: begin
          n = $urandom_range(6, 16);
          repeat (n) begin
            add_rand(FUNC_ENQUEUE, drain);
            add_rand(FUNC_PREEMPT, drain);
          end
          made += 2 * n;
        end
      endcase
    end
  endtask

  // Accept transfers, predict, and check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_results.size());
        $display("priority_ready_queue_scheduler regression: fail");
        $finish;
      end else begin
        if (in_if.valid && in_if.ready) begin
          expected_results.push_back(schedule_step('{func: in_if.func, id: in_if.task_id,
                                                     pri: in_if.task_priority,
                                                     stamp: in_if.enqueue_time,
                                                     drain_first: 1'b0}));
          n_accepted++;
        end
        if (out_if.valid && out_if.ready) check_result();
      end
    end
  end

  // Operation driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (n_offered != n_accepted) begin
      // hold the offered operation until its transfer
    end else if (tx_gap != 0) begin
      tx_gap--;
      in_if.valid <= 1'b0;
    end else if (pending_ops.size() == 0 ||
                 (pending_ops[0].drain_first && expected_results.size() != 0)) begin
      in_if.valid <= 1'b0;
    end else begin
      next_op = pending_ops.pop_front();
      in_if.func          <= next_op.func;
      in_if.task_id       <= next_op.id;
      in_if.task_priority <= next_op.pri;
      in_if.enqueue_time  <= next_op.stamp;
      in_if.valid         <= 1'b1;
      n_offered++;
      tx_gap = tx_steady ? 0 : idle_len();
      if ($urandom_range(0, 79) == 0) tx_steady = !tx_steady;
    end
  end

  // Result receiver with random stalls and two long hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (holds_done < 2 && n_accepted >= (holds_done == 0 ? 400 : 1100)) begin
      hold_left = HOLD_CYCLES - 1;
      holds_done++;
      out_if.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      rx_stall = rx_steady ? 0 : idle_len();
      if ($urandom_range(0, 79) == 0) rx_steady = !rx_steady;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.func          = FUNC_ENQUEUE;
    in_if.task_id       = '0;
    in_if.task_priority = '0;
    in_if.enqueue_time  = '0;
    out_if.ready        = 1'b0;
    ready_len   = 0;
    run_present = 1'b0;
    run_task    = '0;
    build_directed();
    build_random();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_ops.size() != 0 || n_offered != n_accepted || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("ran %0d operations in %0d cycles: %0d tasks queued, %0d rejected as full,",
             n_accepted, cycles, n_enq, n_full);
    $display("%0d dispatches found the queue empty, %0d preemptions swapped, %0d mismatches",
             n_empty, n_swaps, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("priority_ready_queue_scheduler regression: pass");
    end else begin
      $display("priority_ready_queue_scheduler regression: fail");
    end
    $finish;
  end

endmodule
